/* rtl/core/mtm_pkg.sv */
// ----------------------------------------------------------------------------
// MIDI track merge timer package
// Shared codes, constants and the divider handshake types.
// ----------------------------------------------------------------------------
package mtm_pkg;

  localparam logic [1:0] MODE_RESTART = 2'd0;
  localparam logic [1:0] MODE_PUSH_EV = 2'd1;
  localparam logic [1:0] MODE_PUSH_TP = 2'd2;
  localparam logic [1:0] MODE_POP     = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BADDIV = 2'd2;

  localparam logic [15:0] TD_RESET   = 16'd96;
  localparam logic [31:0] MPB_RESET  = 32'd500;
  localparam logic [31:0] MS_PER_S   = 32'd1000;
  localparam logic [31:0] MS_DROP    = 32'd1001;
  localparam logic [6:0]  FPS_DROP   = 7'd29;
  localparam logic [7:0]  FPS_FULL   = 8'd30;
  localparam int          SMPTE_BIT  = 15;
  localparam int          TEMPO_BITS = 24;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [31:0] rem;
  } div_rsp_t;

endpackage

/* rtl/core/mtm_if.sv */
// ----------------------------------------------------------------------------
// MIDI track merge timer channels
// Valid/ready channels for requests, results and the division register.
// ----------------------------------------------------------------------------
interface mtm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [3:0]  track;
  logic [31:0] tick;
  logic [31:0] value;
  modport source (output valid, mode, track, tick, value, input ready);
  modport sink (input valid, mode, track, tick, value, output ready);
endinterface

interface mtm_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] time_ms;
  logic [31:0] event_data;
  modport source (output valid, status, time_ms, event_data, input ready);
  modport sink (input valid, status, time_ms, event_data, output ready);
endinterface

interface mtm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* rtl/core/mtm_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mtm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/mtm_div.sv */
// ----------------------------------------------------------------------------
// Shared divider
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtm_div import mtm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [31:0] dvd;
  logic [31:0] dsr;
  logic [31:0] rem;
  logic [32:0] trial;
  logic        ge;

  assign trial = {rem, dvd[31]};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? 32'(trial - {1'b0, dsr}) : trial[31:0];
      dvd <= {dvd[30:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = dvd;
  assign rsp.rem  = rem;

endmodule

/* rtl/core/midi_track_merge_timer_top.sv */
// ----------------------------------------------------------------------------
// MIDI track merge timer
// Merges per-track event queues by tick and gives each event's time in ms.
// ----------------------------------------------------------------------------
// Restart and push requests complete without leaving the idle state. A pop
// scans every track head, a read state and a compare state per track, then
// runs its arithmetic on one shared multiplier and one shared divider that
// produces a quotient bit per cycle. Each queued tempo change that a
// beat-mode pop applies costs three divisions. The request side is not
// ready while a pop is in progress; pushes are taken while a finished
// result still waits on the response side.
module midi_track_merge_timer_top import mtm_pkg::*; #(
  parameter int TRACKS           = 16,
  parameter int EVENTS_PER_TRACK = 256,
  parameter int TEMPO_DEPTH      = 256
) (
  input logic   clk,
  input logic   rst,
  mtm_req_if.sink   req,
  mtm_rsp_if.source rsp,
  mtm_cfg_if.sink   cfg
);

  localparam int TW  = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int HW  = $clog2(EVENTS_PER_TRACK);
  localparam int CW  = $clog2(EVENTS_PER_TRACK + 1);
  localparam int EVD = TRACKS * EVENTS_PER_TRACK;
  localparam int AW  = (EVD > 1) ? $clog2(EVD) : 1;
  localparam int PW  = $clog2(TEMPO_DEPTH);
  localparam int PCW = $clog2(TEMPO_DEPTH + 1);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_SCAN_RD  = 5'd1;
  localparam logic [4:0] S_SCAN_CMP = 5'd2;
  localparam logic [4:0] S_CHECK    = 5'd3;
  localparam logic [4:0] S_SM_MUL   = 5'd4;
  localparam logic [4:0] S_SM_DIV   = 5'd5;
  localparam logic [4:0] S_SM_WAIT  = 5'd6;
  localparam logic [4:0] S_TP_RD    = 5'd7;
  localparam logic [4:0] S_TP_TEST  = 5'd8;
  localparam logic [4:0] S_MUL_Q    = 5'd9;
  localparam logic [4:0] S_DIV_Q    = 5'd10;
  localparam logic [4:0] S_WAIT_Q   = 5'd11;
  localparam logic [4:0] S_MUL_R    = 5'd12;
  localparam logic [4:0] S_MUL_U    = 5'd13;
  localparam logic [4:0] S_DIV_S    = 5'd14;
  localparam logic [4:0] S_WAIT_S   = 5'd15;
  localparam logic [4:0] S_DIV_T    = 5'd16;
  localparam logic [4:0] S_WAIT_T   = 5'd17;
  localparam logic [4:0] S_DONE     = 5'd18;

  logic [4:0]  state;
  logic [15:0] time_div;

  // Per-track queue pointers, read through one shared index.
  logic [HW-1:0] head_q [TRACKS];
  logic [CW-1:0] cnt_q  [TRACKS];
  logic [TW-1:0] idx;
  logic [HW-1:0] head_rd;
  logic [CW-1:0] cnt_rd;

  logic [PW-1:0]  tp_head;
  logic [PCW-1:0] tp_cnt;

  logic [31:0] accum_tick;
  logic [31:0] accum_time;
  logic [31:0] rem_num;
  logic [31:0] ms_per_beat;
  logic [9:0]  us_rest;

  logic [TW-1:0] scan_t;
  logic          found;
  logic [TW-1:0] best_t;
  logic [HW-1:0] best_head;
  logic [CW-1:0] best_cnt;
  logic [31:0]   best_tick;
  logic [31:0]   best_data;

  logic [31:0] num;
  logic [31:0] den;
  logic [31:0] tpb;
  logic [31:0] acc;
  logic [31:0] dt;
  logic [31:0] qq;
  logic [31:0] r1;
  logic [31:0] tt;
  logic [23:0] td;
  logic        fin;
  logic [1:0]  res_status;
  logic [31:0] res_time;

  logic        req_fire;
  logic [6:0]  trk_ext;
  logic        trk_ok;
  logic [TW-1:0] trk_idx;
  logic        push_ev;
  logic        push_tp;
  logic        restart;
  logic [HW:0] ev_sum;
  logic [HW-1:0] ev_slot;
  logic [PW:0] tp_sum;
  logic [PW-1:0] tp_slot;

  logic [AW-1:0] ev_waddr;
  logic [AW-1:0] ev_raddr;
  logic [63:0]   ev_rdata;
  logic [55:0]   tp_rdata;

  logic [6:0]  fps_raw;
  logic [7:0]  fps_adj;
  logic [15:0] den_sm;
  logic        smpte;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] prod;

  div_req_t dreq;
  div_rsp_t drsp;

  logic out_free;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign req_fire  = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;

  assign trk_ext = {3'b000, req.track};
  assign trk_ok  = trk_ext < 7'(TRACKS);
  assign trk_idx = TW'(trk_ext);

  assign idx     = (state == S_IDLE) ? trk_idx : scan_t;
  assign head_rd = head_q[idx];
  assign cnt_rd  = cnt_q[idx];

  assign restart = req_fire && (req.mode == MODE_RESTART);
  assign push_ev = req_fire && (req.mode == MODE_PUSH_EV) && trk_ok &&
                   (cnt_rd < CW'(EVENTS_PER_TRACK));
  assign push_tp = req_fire && (req.mode == MODE_PUSH_TP) &&
                   (tp_cnt < PCW'(TEMPO_DEPTH));

  assign ev_sum  = (HW+1)'(head_rd) + (HW+1)'(cnt_rd);
  assign ev_slot = (ev_sum >= (HW+1)'(EVENTS_PER_TRACK)) ?
                   HW'(ev_sum - (HW+1)'(EVENTS_PER_TRACK)) : HW'(ev_sum);
  assign tp_sum  = (PW+1)'(tp_head) + (PW+1)'(tp_cnt);
  assign tp_slot = (tp_sum >= (PW+1)'(TEMPO_DEPTH)) ?
                   PW'(tp_sum - (PW+1)'(TEMPO_DEPTH)) : PW'(tp_sum);

  assign ev_waddr = AW'(AW'(trk_idx) * AW'(EVENTS_PER_TRACK)) + AW'(ev_slot);
  assign ev_raddr = AW'(AW'(scan_t) * AW'(EVENTS_PER_TRACK)) + AW'(head_rd);

  mtm_ram #(.WIDTH(64), .DEPTH(EVD)) u_ev_ram (
    .clk   (clk),
    .we    (push_ev),
    .waddr (ev_waddr),
    .wdata ({req.tick, req.value}),
    .raddr (ev_raddr),
    .rdata (ev_rdata)
  );

  mtm_ram #(.WIDTH(56), .DEPTH(TEMPO_DEPTH)) u_tp_ram (
    .clk   (clk),
    .we    (push_tp),
    .waddr (tp_slot),
    .wdata ({req.tick, req.value[TEMPO_BITS-1:0]}),
    .raddr (tp_head),
    .rdata (tp_rdata)
  );

  assign smpte   = time_div[SMPTE_BIT];
  assign fps_raw = time_div[14:8];
  assign fps_adj = (fps_raw == FPS_DROP) ? FPS_FULL : {1'b0, fps_raw};
  assign den_sm  = fps_adj * time_div[7:0];

  // Shared multiplier; only the low 32 bits of a product are kept.
  always_comb begin
    mul_a = dt;
    mul_b = ms_per_beat;
    case (state)
      S_SM_MUL: begin
        mul_a = best_tick;
        mul_b = num;
      end
      S_MUL_R: begin
        mul_a = r1;
        mul_b = MS_PER_S;
      end
      S_MUL_U: begin
        mul_a = dt;
        mul_b = {22'd0, us_rest};
      end
      default: begin
        mul_a = dt;
        mul_b = ms_per_beat;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = acc;
    dreq.divisor  = den;
    case (state)
      S_SM_DIV, S_DIV_S: dreq.start = 1'b1;
      S_DIV_Q: begin
        dreq.start   = 1'b1;
        dreq.divisor = tpb;
      end
      S_DIV_T: begin
        dreq.start    = 1'b1;
        dreq.dividend = {8'd0, td};
        dreq.divisor  = MS_PER_S;
      end
      default: dreq.start = 1'b0;
    endcase
  end

  mtm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      time_div <= TD_RESET;
    end else if (cfg.valid && cfg.ready) begin
      time_div <= cfg.data;
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      for (int i = 0; i < TRACKS; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      tp_head     <= '0;
      tp_cnt      <= '0;
      accum_tick  <= '0;
      accum_time  <= '0;
      rem_num     <= '0;
      ms_per_beat <= MPB_RESET;
      us_rest     <= '0;
    end
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
      found     <= 1'b0;
      scan_t    <= '0;
    end else begin
      // In the done state the result register is refilled instead.
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (push_ev) begin
            cnt_q[trk_idx] <= cnt_rd + CW'(1);
          end
          if (push_tp) begin
            tp_cnt <= tp_cnt + PCW'(1);
          end
          if (req_fire && req.mode == MODE_POP) begin
            scan_t <= '0;
            found  <= 1'b0;
            state  <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: state <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (cnt_rd != '0 && (!found || ev_rdata[63:32] < best_tick)) begin
            found     <= 1'b1;
            best_t    <= scan_t;
            best_head <= head_rd;
            best_cnt  <= cnt_rd;
            best_tick <= ev_rdata[63:32];
            best_data <= ev_rdata[31:0];
          end
          if (scan_t == TW'(TRACKS - 1)) begin
            state <= S_CHECK;
          end else begin
            scan_t <= scan_t + TW'(1);
            state  <= S_SCAN_RD;
          end
        end
        S_CHECK: begin
          tpb <= {17'd0, time_div[14:0]};
          if (!found) begin
            res_status <= ST_EMPTY;
            state      <= S_DONE;
          end else if (smpte) begin
            num <= (fps_raw == FPS_DROP) ? MS_DROP : MS_PER_S;
            den <= {16'd0, den_sm};
            if (den_sm == '0) begin
              res_status <= ST_BADDIV;
              state      <= S_DONE;
            end else begin
              state <= S_SM_MUL;
            end
          end else begin
            den <= 32'({17'd0, time_div[14:0]} * MS_PER_S);
            if (time_div[14:0] == '0) begin
              res_status <= ST_BADDIV;
              state      <= S_DONE;
            end else begin
              state <= S_TP_RD;
            end
          end
        end
        S_SM_MUL: begin
          acc   <= prod;
          state <= S_SM_DIV;
        end
        S_SM_DIV: state <= S_SM_WAIT;
        S_SM_WAIT: begin
          if (drsp.done) begin
            res_status <= ST_OK;
            res_time   <= drsp.quot;
            state      <= S_DONE;
          end
        end
        S_TP_RD: begin
          if (tp_cnt != '0) begin
            state <= S_TP_TEST;
          end else begin
            dt    <= best_tick - accum_tick;
            fin   <= 1'b1;
            state <= S_MUL_Q;
          end
        end
        S_TP_TEST: begin
          tt <= tp_rdata[55:24];
          td <= tp_rdata[23:0];
          if (best_tick > tp_rdata[55:24]) begin
            dt  <= tp_rdata[55:24] - accum_tick;
            fin <= 1'b0;
          end else begin
            dt  <= best_tick - accum_tick;
            fin <= 1'b1;
          end
          state <= S_MUL_Q;
        end
        S_MUL_Q: begin
          acc   <= prod;
          state <= S_DIV_Q;
        end
        S_DIV_Q: state <= S_WAIT_Q;
        S_WAIT_Q: begin
          if (drsp.done) begin
            qq    <= drsp.quot;
            r1    <= drsp.rem;
            state <= S_MUL_R;
          end
        end
        S_MUL_R: begin
          acc   <= prod + rem_num;
          state <= S_MUL_U;
        end
        S_MUL_U: begin
          acc   <= acc + prod;
          state <= S_DIV_S;
        end
        S_DIV_S: state <= S_WAIT_S;
        S_WAIT_S: begin
          if (drsp.done) begin
            if (fin) begin
              res_status <= ST_OK;
              res_time   <= accum_time + qq + drsp.quot;
              state      <= S_DONE;
            end else begin
              accum_time <= accum_time + qq + drsp.quot;
              rem_num    <= drsp.rem;
              accum_tick <= tt;
              tp_head    <= (tp_head == PW'(TEMPO_DEPTH - 1)) ? '0 : tp_head + PW'(1);
              tp_cnt     <= tp_cnt - PCW'(1);
              state      <= S_DIV_T;
            end
          end
        end
        S_DIV_T: state <= S_WAIT_T;
        S_WAIT_T: begin
          if (drsp.done) begin
            ms_per_beat <= drsp.quot;
            us_rest     <= drsp.rem[9:0];
            state       <= S_TP_RD;
          end
        end
        S_DONE: begin
          if (out_free) begin
            rsp.valid      <= 1'b1;
            rsp.status     <= res_status;
            rsp.time_ms    <= (res_status == ST_OK) ? res_time : '0;
            rsp.event_data <= (res_status == ST_OK) ? best_data : '0;
            if (res_status == ST_OK) begin
              head_q[best_t] <= (best_head == HW'(EVENTS_PER_TRACK - 1)) ?
                                '0 : best_head + HW'(1);
              cnt_q[best_t]  <= best_cnt - CW'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/mtm_checker.sv */
// ----------------------------------------------------------------------------
// MIDI track merge timer checker
// Port-level properties of the merge timer, bound to the top level.
// ----------------------------------------------------------------------------
module mtm_checker import mtm_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic [1:0]  req_mode,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  rsp_status,
  input logic [31:0] rsp_time_ms,
  input logic [31:0] rsp_event_data
);

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_EMPTY ||
                   rsp_status == ST_BADDIV))
    else $error("result status code out of range");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status != ST_OK) |-> (rsp_time_ms == '0 && rsp_event_data == '0))
    else $error("failed pop carries nonzero payload");

  a_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_mode == MODE_POP) |=> !req_ready)
    else $error("request side ready right after a pop");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_time_ms)))
    else $error("stalled result dropped or changed");

endmodule

bind midi_track_merge_timer_top mtm_checker u_mtm_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_mode       (req.mode),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_time_ms    (rsp.time_ms),
  .rsp_event_data (rsp.event_data)
);
